// ===== rtl/weighted_euclidean_distance_assert.svh =====
// Assertion macros for the weighted Euclidean distance block.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef WEIGHTED_EUCLIDEAN_DISTANCE_ASSERT_SVH
`define WEIGHTED_EUCLIDEAN_DISTANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WED_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("weighted_euclidean_distance: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("weighted_euclidean_distance: next-cycle check failed");

`endif

// ===== rtl/wed_pkg.sv =====
`timescale 1ns / 1ps

package wed_pkg;

    // Default sizes.
    localparam int MAX_TERMS_DEF = 1024;
    localparam int COEF_BITS_DEF = 16;

    // Fixed field widths.
    localparam int WEIGHT_W  = 16;
    localparam int LIMIT_W   = 11;
    localparam int SUM_W     = 64;
    localparam int DIST_W    = 32;
    localparam int CFG_IDX_W = 8;

    // Weight of 1.0 in unsigned Q4.12.
    localparam logic [WEIGHT_W-1:0] FRAC_ONE = 16'h1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ON = 8'd1;

    // Depth of the queue between the accumulator and the square-root unit.
    localparam int QUEUE_DEPTH = 2;

    // One finished run: the saturated sum and whether any pair was invalid.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             invalid;
    } t_run;

endpackage

// ===== rtl/wed_front.sv =====
`timescale 1ns / 1ps

module wed_front
    import wed_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LIMIT_W-1:0]   i_limit,
    input  logic                 i_weights_on,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COEF_BITS-1:0] i_coef_a,
    input  logic [COEF_BITS-1:0] i_coef_b,
    input  logic [WEIGHT_W-1:0]  i_weight,
    input  logic                 i_both_valid,
    input  logic                 i_last_pair,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_run                 o_push_data
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SQ_W   = 2 * COEF_BITS;
    localparam int TERM_W = SQ_W + WEIGHT_W;

    // Run bookkeeping at the accept point.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_run_inv, n_run_inv;

    // Pipeline registers: stage 1 absolute difference, stage 2 square, stage 3 term.
    logic                 r_s1_valid, r_s2_valid, r_s3_valid;
    logic                 r_s1_last, r_s2_last, r_s3_last;
    logic                 r_s1_inv, r_s2_inv, r_s3_inv;
    logic [COEF_BITS-1:0] r_s1_abs;
    logic [WEIGHT_W-1:0]  r_s1_w, r_s2_w;
    logic [SQ_W-1:0]      r_s2_sq;
    logic [TERM_W-1:0]    r_s3_term;
    logic [SUM_W-1:0]     r_sum, n_sum;

    logic                 w_stall;
    logic                 w_accept;
    logic [LIM_W-1:0]     w_lim;
    logic [LIM_W-1:0]     w_lim_eff;
    logic                 w_use;
    logic                 w_item_inv;
    logic [COEF_BITS:0]   w_diff;
    logic [COEF_BITS-1:0] w_abs;
    logic [SUM_W:0]       w_add;
    logic [SUM_W-1:0]     w_sat;

    // The whole pipeline holds while a finished run cannot enter the queue.
    assign w_stall  = r_s3_valid & r_s3_last & i_q_full;
    assign o_ready  = !w_stall;
    assign w_accept = i_valid & !w_stall;

    // Clamp the limit to the counter range and decide whether this pair is summed.
    always_comb begin
        w_lim     = LIM_W'(i_limit);
        w_lim_eff = (w_lim > LIM_W'(MAX_TERMS)) ? LIM_W'(MAX_TERMS) : w_lim;
        w_use     = (w_lim_eff == '0) || (LIM_W'(r_count) < w_lim_eff);
    end

    assign w_item_inv = r_run_inv | !i_both_valid;

    // Signed difference and its magnitude.
    always_comb begin
        w_diff = $signed({i_coef_a[COEF_BITS-1], i_coef_a})
               - $signed({i_coef_b[COEF_BITS-1], i_coef_b});
        w_abs  = w_diff[COEF_BITS] ? COEF_BITS'(-w_diff) : w_diff[COEF_BITS-1:0];
    end

    // Counter and invalid flag of the current run.
    always_comb begin
        n_count   = r_count;
        n_run_inv = r_run_inv;
        if (w_accept) begin
            if (i_last_pair) begin
                n_count   = '0;
                n_run_inv = 1'b0;
            end else begin
                n_run_inv = w_item_inv;
                if (CNT_W'(MAX_TERMS) > r_count) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // Saturating accumulate of the stage 3 term.
    always_comb begin
        w_add = {1'b0, r_sum} + (SUM_W + 1)'(r_s3_term);
        w_sat = w_add[SUM_W] ? {SUM_W{1'b1}} : w_add[SUM_W-1:0];
        n_sum = r_sum;
        if (r_s3_valid && !w_stall) begin
            n_sum = r_s3_last ? '0 : w_sat;
        end
    end

    assign o_push            = r_s3_valid & r_s3_last & !w_stall;
    assign o_push_data.sum   = w_sat;
    assign o_push_data.invalid = r_s3_inv;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_run_inv  <= 1'b0;
            r_sum      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_run_inv <= n_run_inv;
            r_sum     <= n_sum;
            if (!w_stall) begin
                r_s1_valid <= w_accept;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers; a pair over the limit carries a zero weight.
    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_s1_abs  <= w_abs;
            r_s1_w    <= !w_use ? '0 : (i_weights_on ? i_weight : FRAC_ONE);
            r_s1_last <= i_last_pair;
            r_s1_inv  <= w_item_inv;

            r_s2_sq   <= SQ_W'(r_s1_abs) * SQ_W'(r_s1_abs);
            r_s2_w    <= r_s1_w;
            r_s2_last <= r_s1_last;
            r_s2_inv  <= r_s1_inv;

            r_s3_term <= TERM_W'(r_s2_sq) * TERM_W'(r_s2_w);
            r_s3_last <= r_s2_last;
            r_s3_inv  <= r_s2_inv;
        end
    end

endmodule

// ===== rtl/wed_queue.sv =====
`timescale 1ns / 1ps

module wed_queue
    import wed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_push_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_run o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_run             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage of finished runs.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/wed_sqrt.sv =====
`timescale 1ns / 1ps

module wed_sqrt
    import wed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_run              i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DIST_W-1:0] o_distance,
    output logic              o_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SUM_W-1:0]  r_x, n_x;
    logic [SUM_W-1:0]  r_res, n_res;
    logic [SUM_W-1:0]  r_bit, n_bit;
    logic              r_inv, n_inv;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_distance, n_distance;
    logic              r_status, n_status;
    logic [SUM_W-1:0]  w_trial;

    assign w_trial    = r_res + r_bit;
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid    = r_out_valid;
    assign o_distance = r_distance;
    assign o_status   = r_status;

    // Digit-by-digit square root, one result bit per cycle.
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_res       = r_res;
        n_bit       = r_bit;
        n_inv       = r_inv;
        n_out_valid = r_out_valid;
        n_distance  = r_distance;
        n_status    = r_status;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_x   = i_head.sum;
                    n_res = '0;
                    n_bit = SUM_W'(1) << (SUM_W - 2);
                    n_inv = i_head.invalid;
                    n_state = i_head.invalid ? ST_DONE : ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_x >= w_trial) begin
                    n_x   = r_x - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == SUM_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_distance  = r_inv ? '0 : r_res[DIST_W-1:0];
                    n_status    = r_inv;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_res      <= n_res;
        r_bit      <= n_bit;
        r_inv      <= n_inv;
        r_distance <= n_distance;
        r_status   <= n_status;
    end

endmodule

// ===== rtl/weighted_euclidean_distance.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------------------
// pairs    | in        | i_in_valid / o_in_ready    | coef_a, coef_b, weight, both_valid, last_pair
// results  | out       | o_out_valid / i_out_ready  | distance, status
// config   | in        | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
// Pairs are taken one per cycle unless the pipeline stalls; an accepted pair passes the
// difference, square and term registers before it reaches the accumulator. The square-root
// unit computes one root bit per cycle, then fills the output register; an invalid run skips
// the iterations. A two-entry queue holds finished sums; pairs stall only when a last pair
// reaches the accumulator while that queue is full. Reset is synchronous and active low.

`include "weighted_euclidean_distance_assert.svh"

module weighted_euclidean_distance
    import wed_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [COEF_BITS-1:0] i_coef_a,
    input  logic [COEF_BITS-1:0] i_coef_b,
    input  logic [WEIGHT_W-1:0]  i_weight,
    input  logic                 i_both_valid,
    input  logic                 i_last_pair,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DIST_W-1:0]    o_distance,
    output logic                 o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    logic [LIMIT_W-1:0] r_term_limit;
    logic               r_weights_on;
    logic               w_push;
    t_run               w_push_data;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_pop;
    t_run               w_head;

    // Configuration registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_limit <= '0;
            r_weights_on <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TERM_LIMIT: r_term_limit <= i_cfg_data;
                CFG_WEIGHTS_ON: r_weights_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front end: difference, square, weight and accumulate.
    wed_front #(
        .MAX_TERMS (MAX_TERMS),
        .COEF_BITS (COEF_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limit      (r_term_limit),
        .i_weights_on (r_weights_on),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_coef_a     (i_coef_a),
        .i_coef_b     (i_coef_b),
        .i_weight     (i_weight),
        .i_both_valid (i_both_valid),
        .i_last_pair  (i_last_pair),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // Queue of finished runs between the two sides.
    wed_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_head      (w_head)
    );

    // Back end: square root and output register.
    wed_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_distance (o_distance),
        .o_status   (o_status)
    );

    // An invalid run always reports a zero distance.
    `WED_ASSERT_NOW(a_invalid_zero, o_out_valid && o_status, o_distance == '0)
    // A finished run is never pushed into a full queue.
    `WED_ASSERT_NOW(a_no_overflow, w_push, !w_q_full)
    // Pairs are held back only because the queue is full.
    `WED_ASSERT_NOW(a_stall_cause, !o_in_ready, w_q_full)
    // A push without a pop leaves a run waiting in the queue.
    `WED_ASSERT_NEXT(a_push_lands, w_push && !w_pop, w_q_valid)

endmodule

// ===== tb/sv/tb_weighted_euclidean_distance.sv =====
`timescale 1ns / 1ps

module tb_weighted_euclidean_distance;
    import wed_pkg::*;

    localparam int CB           = COEF_BITS_DEF;
    localparam int TERMS_CAP    = MAX_TERMS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLS = 10;
    localparam int DRAIN_CYCLS  = 60;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    localparam logic [CB-1:0] COEF_MAX  = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] COEF_MIN  = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] COEF_ONE  = 16'h1000;
    localparam logic [WEIGHT_W-1:0] W_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CB-1:0]       coef_a;
        logic [CB-1:0]       coef_b;
        logic [WEIGHT_W-1:0] weight;
        logic                both_valid;
        logic                last_pair;
    } t_pair;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              status;
    } t_dist;

    typedef enum {ROW_PAIR, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        t_pair                pair;
        bit                   typed;
        t_dist                typed_val;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [LIMIT_W-1:0]   cfg_data;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CB-1:0]        i_coef_a = '0;
    logic [CB-1:0]        i_coef_b = '0;
    logic [WEIGHT_W-1:0]  i_weight = '0;
    logic                 i_both_valid = 1'b0;
    logic                 i_last_pair = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [DIST_W-1:0]    o_distance;
    logic                 o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;

    weighted_euclidean_distance i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_coef_a     (i_coef_a),
        .i_coef_b     (i_coef_b),
        .i_weight     (i_weight),
        .i_both_valid (i_both_valid),
        .i_last_pair  (i_last_pair),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_distance   (o_distance),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow of the block: configuration and the state of the open run.
    logic [LIMIT_W-1:0] cur_limit = '0;
    bit                 cur_weights = 1'b0;
    logic [SUM_W-1:0]   run_sum = '0;
    int unsigned        run_terms = 0;
    bit                 run_bad = 1'b0;

    t_dist dist_expected[$];
    t_row  directed_rows[$];

    int send_idle_pct = 11;
    int recv_idle_pct = 62;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int pairs_sent = 0;
    int dists_checked = 0;
    int invalid_seen = 0;
    int reg_writes = 0;
    int sat_seen = 0;

    always #6 i_clk = ~i_clk;

    // Floor square root, one result bit per step from the top.
    function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] root;
        logic [SUM_W-1:0] cand;
        root = '0;
        for (int i = DIST_W - 1; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= x) begin
                root = cand;
            end
        end
        return root[DIST_W-1:0];
    endfunction

    // Fold one pair into the run sum; a last pair closes the run with a distance.
    function automatic void predict_distance(input t_pair p, output bit has, output t_dist d);
        longint           diff;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] term;
        logic [SUM_W:0]   total;
        int unsigned      lim;
        lim = (cur_limit > TERMS_CAP) ? TERMS_CAP : cur_limit;
        if (!p.both_valid) begin
            run_bad = 1'b1;
        end
        if (lim == 0 || run_terms < lim) begin
            diff = longint'($signed(p.coef_a)) - longint'($signed(p.coef_b));
            mag = (diff < 0) ? -diff : diff;
            term = mag * mag * (cur_weights ? {48'd0, p.weight} : {48'd0, FRAC_ONE});
            total = {1'b0, run_sum} + {1'b0, term};
            run_sum = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
        end
        if (run_terms < TERMS_CAP) begin
            run_terms++;
        end
        has = p.last_pair;
        d = '0;
        if (p.last_pair) begin
            d.status = run_bad;
            d.distance = run_bad ? '0 : floor_root(run_sum);
            run_sum = '0;
            run_terms = 0;
            run_bad = 1'b0;
        end
    endfunction

    function automatic t_row pair_row(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                      input logic [WEIGHT_W-1:0] w, input bit v, input bit l,
                                      input bit typed = 1'b0,
                                      input logic [DIST_W-1:0] dist_val = '0,
                                      input bit st = 1'b0);
        t_row r;
        r.kind = ROW_PAIR;
        r.pair = '{coef_a: a, coef_b: b, weight: w, both_valid: v, last_pair: l};
        r.typed = typed;
        r.typed_val = '{distance: dist_val, status: st};
        r.cfg_idx = '0;
        r.cfg_data = '0;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [LIMIT_W-1:0] data);
        t_row r;
        r = pair_row('0, '0, '0, 1'b0, 1'b0);
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    // Coefficients lean toward the extremes and zero.
    function automatic logic [CB-1:0] rand_coef();
        case ($urandom_range(9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return CB'($urandom_range(255));
            default: return CB'($urandom);
        endcase
    endfunction

    // Offer one pair and record its expectation once the request is taken.
    task automatic send_pair(input t_pair p, input bit typed = 1'b0,
                             input t_dist typed_val = '0);
        bit    has;
        t_dist d;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_coef_a     <= p.coef_a;
        i_coef_b     <= p.coef_b;
        i_weight     <= p.weight;
        i_both_valid <= p.both_valid;
        i_last_pair  <= p.last_pair;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_distance(p, has, d);
        if (has) begin
            dist_expected.push_back(typed ? typed_val : d);
        end
        pairs_sent++;
    endtask

    // Stop offering pairs and let every pending distance come out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (dist_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_TERM_LIMIT) begin
            cur_limit = data;
        end else if (idx == CFG_WEIGHTS_ON) begin
            cur_weights = data[0];
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Whole runs with random content; a few carry an invalid flag.
    task automatic random_runs(input int n_items);
        int    sent;
        int    len;
        int    pick;
        t_pair p;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            len = (pick < 50) ? $urandom_range(1, 4)
                : (pick < 85) ? $urandom_range(5, 16) : $urandom_range(17, 60);
            for (int k = 0; k < len; k++) begin
                p.coef_a = rand_coef();
                p.coef_b = rand_coef();
                case ($urandom_range(7))
                    0: p.weight = '0;
                    1: p.weight = W_MAX;
                    2: p.weight = FRAC_ONE;
                    default: p.weight = WEIGHT_W'($urandom);
                endcase
                p.both_valid = ($urandom_range(99) >= 4);
                p.last_pair = (k == len - 1);
                send_pair(p);
            end
            sent += len;
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each distance taken from the block with the oldest expectation.
    always @(posedge i_clk) begin
        t_dist want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (dist_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected distance %0d status %0d at cycle %0d",
                             o_distance, o_status, cycle_count);
                end
            end else begin
                want = dist_expected.pop_front();
                dists_checked++;
                if (o_status) begin
                    invalid_seen++;
                end
                if (o_distance == {DIST_W{1'b1}}) begin
                    sat_seen++;
                end
                if (o_distance !== want.distance || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d: expected distance %0d status %0d, %s",
                                 cycle_count, want.distance, want.status, "got below");
                        $display("    got distance %0d status %0d", o_distance, o_status);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d distances outstanding",
                     cycle_count, dist_expected.size());
            $display("tb_weighted_euclidean_distance: done, errors");
            $finish;
        end
    end

    initial begin
        t_pair p;
        int    pick;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: one-term runs with known distances, extremes, invalid runs,
        // ignored register writes, and the term limit.
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 1, 1, 32'd262144, 0));
        directed_rows.push_back(pair_row('0, '0, W_MAX, 1, 1, 1, 32'd0, 0));
        directed_rows.push_back(pair_row(COEF_MIN, COEF_MAX, '0, 1, 0));
        directed_rows.push_back(pair_row(COEF_MAX, COEF_MIN, W_MAX, 1, 1));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 0, 0));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 1, 1, 32'd0, 1));
        directed_rows.push_back(pair_row(COEF_MAX, '0, '0, 0, 1, 1, 32'd0, 1));
        directed_rows.push_back(cfg_row(CFG_WEIGHTS_ON, 11'd1));
        directed_rows.push_back(pair_row(COEF_ONE, '0, FRAC_ONE, 1, 1, 1, 32'd262144, 0));
        directed_rows.push_back(pair_row(COEF_MAX, COEF_MIN, W_MAX, 1, 1));
        directed_rows.push_back(pair_row(16'h1234, '0, '0, 1, 1, 1, 32'd0, 0));
        directed_rows.push_back(pair_row(COEF_MIN, COEF_ONE, 16'h8001, 1, 1));
        // Bit zero clear turns weighting off even with other data bits set.
        directed_rows.push_back(cfg_row(CFG_WEIGHTS_ON, 11'd2));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 1, 1, 32'd262144, 0));
        directed_rows.push_back(cfg_row(CFG_UNUSED_LO, 11'd1));
        directed_rows.push_back(cfg_row(CFG_UNUSED_HI, 11'h7FF));
        directed_rows.push_back(pair_row('0, COEF_ONE, '0, 1, 1, 1, 32'd262144, 0));
        // With a limit of one, the second pair is dropped from the sum.
        directed_rows.push_back(cfg_row(CFG_TERM_LIMIT, 11'd1));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 0));
        directed_rows.push_back(pair_row(COEF_MAX, COEF_MIN, '0, 1, 1, 1, 32'd262144, 0));
        // A pair beyond the limit still marks the run invalid.
        directed_rows.push_back(cfg_row(CFG_TERM_LIMIT, 11'd2));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 0));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 1, 0));
        directed_rows.push_back(pair_row(COEF_ONE, '0, '0, 0, 1, 1, 32'd0, 1));
        directed_rows.push_back(cfg_row(CFG_TERM_LIMIT, 11'd1024));
        directed_rows.push_back(pair_row(COEF_MAX, '0, '0, 1, 0));
        directed_rows.push_back(pair_row('0, COEF_MIN, '0, 1, 1));
        directed_rows.push_back(cfg_row(CFG_TERM_LIMIT, 11'd0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
            end else begin
                send_pair(directed_rows[i].pair, directed_rows[i].typed,
                          directed_rows[i].typed_val);
            end
        end

        // Random runs in chunks, with new settings between chunks.
        for (int chunk = 0; chunk < 11; chunk++) begin
            wait_idle();
            if (chunk == 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 11;
            end else if (chunk == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Receiver holds off while short runs keep coming, so the block backs up.
                hold_req++;
                for (int k = 0; k < 40; k++) begin
                    p = '{coef_a: rand_coef(), coef_b: rand_coef(),
                          weight: WEIGHT_W'($urandom), both_valid: 1'b1,
                          last_pair: ($urandom_range(2) != 0)};
                    p.last_pair = p.last_pair || (k == 39);
                    send_pair(p);
                end
                wait_idle();
            end
            pick = $urandom_range(6);
            case (pick)
                0: write_reg(CFG_TERM_LIMIT, 11'd0);
                1: write_reg(CFG_TERM_LIMIT, 11'd1);
                2: write_reg(CFG_TERM_LIMIT, 11'd1024);
                3: write_reg(CFG_TERM_LIMIT, 11'h7FF);
                4: write_reg(CFG_TERM_LIMIT, LIMIT_W'($urandom));
                default: write_reg(CFG_TERM_LIMIT, LIMIT_W'($urandom_range(2, 20)));
            endcase
            write_reg(CFG_WEIGHTS_ON, LIMIT_W'($urandom_range(1)));
            random_runs(80);
        end

        wait_idle();
        repeat (DRAIN_CYCLS) @(posedge i_clk);

        $display("summary: %0d pairs sent, %0d register writes, %0d distances checked",
                 pairs_sent, reg_writes, dists_checked);
        $display("summary: %0d invalid runs, %0d saturated sums, %0d mismatches",
                 invalid_seen, sat_seen, mismatches);
        if (mismatches == 0 && dist_expected.size() == 0) begin
            $display("tb_weighted_euclidean_distance: done, clean");
        end else begin
            $display("tb_weighted_euclidean_distance: done, errors");
        end
        $finish;
    end

endmodule
